FILE: sv/mi_pkg.sv
// Shared types of the modular inverse block.
package mi_pkg;

  // Status of the shared divide / multiply-accumulate unit
  typedef struct packed {
    logic busy;   // a division is in progress
    logic done;   // division finished, results valid this cycle
  } div_status_t;

endpackage

FILE: sv/mi_divstep.sv
// Shared restoring divider that also accumulates quotient times a multiplicand.
module mi_divstep #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [OPERAND_BITS-1:0] dividend,
  input  logic [OPERAND_BITS-1:0] divisor,
  input  logic [OPERAND_BITS-1:0] multiplicand,
  output mi_pkg::div_status_t     status,
  output logic [OPERAND_BITS-1:0] remainder,
  output logic [OPERAND_BITS:0]   product
);

  localparam int CntW = $clog2(OPERAND_BITS + 1);
  localparam logic [CntW-1:0] StepsInit = CntW'(OPERAND_BITS);
  localparam logic [CntW-1:0] CntOne    = CntW'(1);

  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [OPERAND_BITS-1:0] dvd_r, dvd_nxt;
  logic [OPERAND_BITS-1:0] dvs_r, dvs_nxt;
  logic [OPERAND_BITS-1:0] mcd_r, mcd_nxt;
  logic [OPERAND_BITS-1:0] rem_r, rem_nxt;
  logic [OPERAND_BITS:0]   acc_r, acc_nxt;
  logic [OPERAND_BITS:0]   trial;
  logic [OPERAND_BITS:0]   diff;
  logic                    ge;

  // One quotient bit: shift in next dividend bit, trial subtract
  assign trial = {rem_r, dvd_r[OPERAND_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    mcd_nxt  = mcd_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    if (go) begin
      // load operands, clear partial remainder and product
      cnt_nxt  = StepsInit;
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      mcd_nxt  = multiplicand;
      rem_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // advance one bit: remainder update and shift-add of the product
      dvd_nxt = {dvd_r[OPERAND_BITS-2:0], 1'b0};
      rem_nxt = ge ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
      acc_nxt = {acc_r[OPERAND_BITS-1:0], 1'b0} + (ge ? {1'b0, mcd_r} : '0);
      cnt_nxt = cnt_r - CntOne;
      if (cnt_r == CntOne) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    mcd_r <= mcd_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign remainder   = rem_r;
  assign product     = acc_r;

endmodule

FILE: sv/modular_inverse.sv
// Top level of the modular inverse block: Euclid sequencer around the shared divider.
//
// Takes one (value, modulus) beat when start is high and busy is low, and returns
// inverse and no_inverse for exactly one cycle marked by out_valid; the receiver
// cannot stall, so every result must be captured in that cycle. The first step
// reduces value modulo modulus, then each extended Euclid step runs one division
// through the shared bit-serial divider, so an item takes longer the more quotient
// steps it needs. busy stays high from acceptance until the result is shown. A
// modulus of zero or operands that share a factor give no_inverse with inverse 0;
// a modulus of one gives inverse 0.
module modular_inverse #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] in_value,
  input  logic [OPERAND_BITS-1:0] in_modulus,
  output logic                    out_valid,
  output logic [OPERAND_BITS-1:0] out_inverse,
  output logic                    out_no_inverse
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [OPERAND_BITS-1:0] OpOne = OPERAND_BITS'(1);

  logic [2:0]              state_r, state_nxt;
  logic [OPERAND_BITS-1:0] m_r, m_nxt;
  logic [OPERAND_BITS-1:0] r0_r, r0_nxt;
  logic [OPERAND_BITS-1:0] r1_r, r1_nxt;
  logic [OPERAND_BITS-1:0] mag0_r, mag0_nxt;
  logic [OPERAND_BITS-1:0] mag1_r, mag1_nxt;
  logic                    neg0_r, neg0_nxt;
  logic                    neg1_r, neg1_nxt;
  logic                    valid_r, valid_nxt;
  logic [OPERAND_BITS-1:0] inv_r, inv_nxt;
  logic                    noinv_r, noinv_nxt;

  logic                    div_go;
  logic [OPERAND_BITS-1:0] div_dividend;
  logic [OPERAND_BITS-1:0] div_divisor;
  logic [OPERAND_BITS-1:0] div_mcand;
  mi_pkg::div_status_t     div_status;
  logic [OPERAND_BITS-1:0] div_rem;
  logic [OPERAND_BITS:0]   div_prod;
  logic [OPERAND_BITS:0]   coef_sum;
  logic [OPERAND_BITS-1:0] inv_cand;

  mi_divstep #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_divstep (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (div_go),
    .dividend    (div_dividend),
    .divisor     (div_divisor),
    .multiplicand(div_mcand),
    .status      (div_status),
    .remainder   (div_rem),
    .product     (div_prod)
  );

  // New coefficient magnitude: mag0 + q * mag1
  assign coef_sum = div_prod + {1'b0, mag0_r};

  // Fold the signed coefficient into 0 .. modulus-1
  assign inv_cand = (neg0_r && (mag0_r != '0)) ? (m_r - mag0_r) : mag0_r;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    m_nxt        = m_r;
    r0_nxt       = r0_r;
    r1_nxt       = r1_r;
    mag0_nxt     = mag0_r;
    mag1_nxt     = mag1_r;
    neg0_nxt     = neg0_r;
    neg1_nxt     = neg1_r;
    valid_nxt    = 1'b0;
    inv_nxt      = inv_r;
    noinv_nxt    = noinv_r;
    div_go       = 1'b0;
    div_dividend = r0_r;
    div_divisor  = r1_r;
    div_mcand    = mag1_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          m_nxt = in_modulus;
          if (in_modulus == '0) begin
            // no modulus: gcd test fails on r0 = 0
            r0_nxt    = '0;
            r1_nxt    = '0;
            state_nxt = S_TEST;
          end else begin
            // reduce value modulo modulus first
            r0_nxt       = in_modulus;
            div_go       = 1'b1;
            div_dividend = in_value;
            div_divisor  = in_modulus;
            div_mcand    = '0;
            state_nxt    = S_RED;
          end
        end
      end
      S_RED: begin
        if (div_status.done) begin
          r1_nxt    = div_rem;
          mag0_nxt  = '0;
          mag1_nxt  = OpOne;
          neg0_nxt  = 1'b0;
          neg1_nxt  = 1'b0;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (r1_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          mag0_nxt  = mag1_r;
          mag1_nxt  = coef_sum[OPERAND_BITS-1:0];
          neg0_nxt  = neg1_r;
          neg1_nxt  = ~neg1_r;
          state_nxt = S_TEST;
        end
      end
      S_FIN: begin
        valid_nxt = 1'b1;
        if (r0_r != OpOne) begin
          inv_nxt   = '0;
          noinv_nxt = 1'b1;
        end else begin
          inv_nxt   = (inv_cand >= m_r) ? '0 : inv_cand;
          noinv_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    mag0_r  <= mag0_nxt;
    mag1_r  <= mag1_nxt;
    neg0_r  <= neg0_nxt;
    neg1_r  <= neg1_nxt;
    inv_r   <= inv_nxt;
    noinv_r <= noinv_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = valid_r;
  assign out_inverse    = inv_r;
  assign out_no_inverse = noinv_r;

`ifndef SYNTHESIS
  // a result beat follows only the final state
  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_FIN)
    else $error("result strobe without a finished item");

  // a flagged result carries a zero inverse
  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_inverse) |-> (out_inverse == '0))
    else $error("no_inverse with nonzero inverse");

  // the divider is never busy while the sequencer is idle
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_status.busy)
    else $error("divider busy while block idle");

  // an inverse stays below its modulus
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_no_inverse && (m_r != '0)) |-> (out_inverse < m_r))
    else $error("inverse out of range");
`endif

endmodule

FILE: bench/modular_inverse_tb.sv
// Testbench for the modular inverse block: directed corners, random operand beats, idle gaps.
module modular_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          OPERAND_BITS = 31;
  localparam int unsigned OPERAND_MAX  = 32'h7FFF_FFFF;
  localparam int unsigned FIB_46       = 1836311903;
  localparam int unsigned FIB_45       = 1134903170;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] value;
    logic [OPERAND_BITS-1:0] modulus;
    logic [OPERAND_BITS-1:0] inverse;
    logic                    no_inverse;
  } inverse_beat_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OPERAND_BITS-1:0] in_value = '0;
  logic [OPERAND_BITS-1:0] in_modulus = '0;
  logic                    out_valid;
  logic [OPERAND_BITS-1:0] out_inverse;
  logic                    out_no_inverse;

  inverse_beat_t pending_inverses[$];
  int            mismatch_count = 0;
  int            sender_idle_pct = 0;
  int            quiet_cycles = 0;

  modular_inverse #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_modulus(in_modulus),
    .out_valid(out_valid),
    .out_inverse(out_inverse),
    .out_no_inverse(out_no_inverse)
  );

  // Run a 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the expected inverse with a sign-magnitude Bezout coefficient
  function automatic inverse_beat_t predict_inverse(logic [OPERAND_BITS-1:0] val,
                                                    logic [OPERAND_BITS-1:0] modv);
    inverse_beat_t res;
    bit [63:0]     rem_hi;
    bit [63:0]     rem_lo;
    bit [63:0]     coef_prev;
    bit [63:0]     coef_cur;
    bit [63:0]     quot;
    bit [63:0]     tmp;
    bit            neg_prev;
    bit            neg_cur;
    res.value      = val;
    res.modulus    = modv;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    if (modv == '0)
      return res;
    rem_hi    = 64'(modv);
    rem_lo    = 64'(val) % rem_hi;
    coef_prev = 64'd0;
    neg_prev  = 1'b0;
    coef_cur  = 64'd1;
    neg_cur   = 1'b0;
    // Step Euclid; the coefficient sign flips at every quotient
    while (rem_lo != 64'd0) begin
      quot      = rem_hi / rem_lo;
      tmp       = rem_hi - quot * rem_lo;
      rem_hi    = rem_lo;
      rem_lo    = tmp;
      tmp       = coef_prev + quot * coef_cur;
      coef_prev = coef_cur;
      neg_prev  = neg_cur;
      coef_cur  = tmp;
      neg_cur   = !neg_cur;
    end
    if (rem_hi != 64'd1)
      return res;
    tmp = (neg_prev && coef_prev != 64'd0) ? 64'(modv) - coef_prev : coef_prev;
    if (tmp >= 64'(modv))
      tmp = 64'd0;
    res.inverse    = tmp[OPERAND_BITS-1:0];
    res.no_inverse = 1'b0;
    return res;
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    inverse_beat_t exp_beat;
    if (rst_n && out_valid) begin
      if (pending_inverses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: inverse=%0d no_inverse=%0b",
                   out_inverse, out_no_inverse);
      end else begin
        exp_beat = pending_inverses.pop_front();
        if (out_inverse !== exp_beat.inverse || out_no_inverse !== exp_beat.no_inverse) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch value=%0d modulus=%0d: expected inverse=%0d no_inverse=%0b,%s",
                     exp_beat.value, exp_beat.modulus, exp_beat.inverse,
                     exp_beat.no_inverse,
                     $sformatf(" got inverse=%0d no_inverse=%0b",
                               out_inverse, out_no_inverse));
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one beat, idling at random first; start stays high for a following beat
  task automatic send_item(int unsigned val, int unsigned modv);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_value   <= val[OPERAND_BITS-1:0];
    in_modulus <= modv[OPERAND_BITS-1:0];
    start      <= 1'b1;
    do
      @(posedge clk);
    while (busy);
    pending_inverses.push_back(predict_inverse(in_value, in_modulus));
  endtask

  // Hold the sender until every expected result has come
  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_inverses.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_corner_cases();
    sender_idle_pct = 0;
    send_item(0, 1);
    send_item(OPERAND_MAX, 1);
    send_item(0, 7);
    send_item(0, OPERAND_MAX);
    send_item(12, 12);
    send_item(24, 12);
    send_item(6, 9);
    send_item(1, OPERAND_MAX);
    send_item(OPERAND_MAX, OPERAND_MAX);
    send_item(OPERAND_MAX - 1, OPERAND_MAX);
    send_item(3, OPERAND_MAX);
    send_item(OPERAND_MAX, 2);
    send_item(OPERAND_MAX, OPERAND_MAX - 1);
    send_item(OPERAND_MAX - 1, OPERAND_MAX - 1);
    send_item(FIB_45, FIB_46);
    send_item(FIB_46, FIB_45);
    send_item(100, 7);
    send_item(1, 2);
    send_item(5, 0);
    send_item(0, 0);
    send_item(3, 7);
  endtask

  // Short Euclid chains: small and 16-bit moduli
  task automatic test_small_moduli(int idle_pct, int count);
    int unsigned modv;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(0, 1) == 0)
        modv = $urandom_range(1, 255);
      else
        modv = $urandom_range(2, 65535);
      send_item($urandom_range(0, 4 * modv), modv);
    end
  endtask

  // Full-width operands, with the prime modulus now and then
  task automatic test_full_range(int idle_pct, int count);
    int unsigned modv;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      modv = ($urandom_range(0, 3) == 0) ? OPERAND_MAX : $urandom_range(1, OPERAND_MAX);
      send_item($urandom_range(0, OPERAND_MAX), modv);
    end
  endtask

  // Operands built on a common factor, so no inverse exists
  task automatic test_shared_factors(int idle_pct, int count);
    int unsigned factor;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      factor = $urandom_range(2, 1000);
      send_item(factor * $urandom_range(0, OPERAND_MAX / factor),
                factor * $urandom_range(1, OPERAND_MAX / factor));
    end
  endtask

  // Drain first, then a random mix of every operand kind
  task automatic test_mixed_after_drain(int idle_pct, int count);
    wait_results_drained();
    repeat (count / 4) begin
      test_small_moduli(idle_pct, 1);
      test_full_range(idle_pct, 1);
      test_shared_factors(idle_pct, 1);
      sender_idle_pct = idle_pct;
      send_item($urandom_range(0, OPERAND_MAX), $urandom_range(0, 1) ? 1 : 2);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_small_moduli(0, 100);
    test_full_range(87, 100);
    test_shared_factors(16, 100);
    test_mixed_after_drain(0, 100);

    // Drop start and let the last result out
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_inverses.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
